// ===== sv/dfops_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfops_pkg: shared types and constants for dragonfly output port selection
// Field widths, command and mode codes, register indexes and pipeline records.
// ----------------------------------------------------------------------------
package dfops_pkg;

    localparam int NODE_W          = 16;
    localparam int CFG_W           = 7;
    localparam int PROXY_W         = 6;
    localparam int TBL_W           = 12;
    localparam int PORT_W          = 8;
    localparam int ROUTE_DEPTH     = 4096;
    localparam int RT_AW           = 12;
    localparam int MAX_GROUPS      = 64;
    localparam int MAX_GROUP_PORTS = 4096;
    localparam int RM_IDX_W        = 16;
    localparam int OG_W            = 18;
    localparam int Q_DEPTH         = 4;
    localparam int S_DATA_W        = 64;
    localparam int M_DATA_W        = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SERVERS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCHES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPLINKS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUPS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SRV_CNT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd5;

    // wiring modes
    localparam logic [2:0] MODE_ABS   = 3'd0;
    localparam logic [2:0] MODE_REL   = 3'd1;
    localparam logic [2:0] MODE_CIRC  = 3'd2;
    localparam logic [2:0] MODE_TABLE = 3'd3;
    localparam logic [2:0] MODE_REMAP = 3'd4;

    typedef enum logic [1:0] {
        CMD_ROUTE = 2'd0,
        CMD_WR_RT = 2'd1,
        CMD_WR_RM = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    // effective configuration, zero p, a, h and g already read as one
    typedef struct packed {
        logic [CFG_W-1:0]  p;
        logic [CFG_W-1:0]  a;
        logic [CFG_W-1:0]  h;
        logic [CFG_W-1:0]  g;
        logic [NODE_W-1:0] sc;
        logic [2:0]        mode;
    } cfg_t;

    typedef struct packed {
        cmd_t              cmd;
        logic              is_sw;
        logic [NODE_W-1:0] cur_sw;
        logic [NODE_W-1:0] dst;
        logic [PROXY_W-1:0] proxy;
        logic [TBL_W-1:0]  tidx;
        logic [TBL_W-1:0]  tval;
    } item_t;

    typedef struct packed {
        item_t             it;
        logic [NODE_W-1:0] dst_sw;
        logic [CFG_W-1:0]  dst_mp;
        logic [NODE_W-1:0] cur_grp;
        logic [CFG_W-1:0]  local_sw;
        logic [NODE_W-1:0] dst_grp;
        logic [CFG_W-1:0]  dst_la;
        logic              done;
        logic [PORT_W-1:0] port;
        logic [NODE_W-1:0] tgt;
        logic [16:0]       diff;
        logic [NODE_W-1:0] abs_og;
        logic [RT_AW-1:0]  rt_idx;
        logic              v_neg;
        logic [16:0]       v_abs;
        logic [17:0]       ct;
        logic [OG_W-1:0]   circ_og;
        logic [CFG_W-1:0]  tm;
        logic [RM_IDX_W-1:0] rm_idx;
    } pipe_t;

endpackage

// ===== sv/dragonfly_output_port_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dragonfly_output_port_select: per-hop output port selection, dragonfly
// Picks the output port for a packet header at a server or switch.
// ----------------------------------------------------------------------------
//  channel  dir  width  content
//  s_       in   64     route request or table write
//  m_       out  16     chosen port and mode error
//  cfg_     in   16     register writes, no read-back
//
// One request per cycle sustained while results are accepted; a route result
// passes five one-bit-per-stage dividers (two in parallel) and the C1 to C3
// and table registers. Reset is synchronous and clears pipeline
// valids and queue; tables are undefined until written. A stalled result holds
// the whole pipeline; the four-entry queue keeps taking requests until full.
module dragonfly_output_port_select (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [1:0] cmd, [17:2] current_node, [33:18] dest_server, [39:34] proxy_group,
    // [51:40] table_index, [63:52] table_value
    input  logic [dfops_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] out_port, [8] mode_error, [15:9] zero
    output logic [dfops_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [dfops_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dfops_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import dfops_pkg::*;

    logic [CFG_W-1:0]  p_reg, a_reg, h_reg, g_reg;
    logic [NODE_W-1:0] sc_reg;
    logic [2:0]        mode_reg;
    cfg_t              cfg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_reg    <= 7'd4;
            a_reg    <= 7'd8;
            h_reg    <= 7'd4;
            g_reg    <= 7'd33;
            sc_reg   <= 16'd1056;
            mode_reg <= MODE_ABS;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SERVERS:  p_reg    <= cfg_wdata[CFG_W-1:0];
                CFG_SWITCHES: a_reg    <= cfg_wdata[CFG_W-1:0];
                CFG_UPLINKS:  h_reg    <= cfg_wdata[CFG_W-1:0];
                CFG_GROUPS:   g_reg    <= cfg_wdata[CFG_W-1:0];
                CFG_SRV_CNT:  sc_reg   <= cfg_wdata[NODE_W-1:0];
                CFG_MODE:     mode_reg <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    // zero p, a, h and g act as one
    always_comb begin
        cfg.p    = (p_reg == '0) ? 7'd1 : p_reg;
        cfg.a    = (a_reg == '0) ? 7'd1 : a_reg;
        cfg.h    = (h_reg == '0) ? 7'd1 : h_reg;
        cfg.g    = (g_reg == '0) ? 7'd1 : g_reg;
        cfg.sc   = sc_reg;
        cfg.mode = mode_reg;
    end

    logic  q_full, q_push, q_pop, q_valid;
    item_t f_item, q_item;

    dfops_front u_front (
        .s_tvalid, .s_tready, .s_tdata, .cfg,
        .q_full, .q_push, .q_item(f_item)
    );

    dfops_queue #(.DEPTH(Q_DEPTH)) u_queue (
        .aclk, .aresetn, .push(q_push), .din(f_item), .full(q_full),
        .pop(q_pop), .valid(q_valid), .dout(q_item)
    );

    dfops_back u_back (
        .aclk, .aresetn, .cfg, .q_valid, .q_item, .q_pop,
        .m_tvalid, .m_tready, .m_tdata
    );
endmodule

// ===== sv/dfops_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfops_div: pipelined restoring divider
// One quotient bit per stage, NW stages, carries a sideband record along.
// ----------------------------------------------------------------------------
module dfops_div #(
    parameter int NW = 16,
    parameter int DW = 7,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    input  logic [SW-1:0] side_i,
    output logic          out_valid,
    output logic [NW-1:0] quot,
    output logic [DW-1:0] rem,
    output logic [SW-1:0] side_o
);
    for (genvar i = 0; i < NW; i++) begin : g_stage
        logic          v_in;
        logic [NW-1:0] n_in;
        logic [DW-1:0] r_in;
        logic [SW-1:0] s_in;
        logic [DW:0]   sh;
        logic [DW+1:0] trial;
        logic          ge;
        logic          v_reg;
        logic [NW-1:0] n_reg;
        logic [DW-1:0] r_reg;
        logic [SW-1:0] s_reg;

        if (i == 0) begin : g_first
            assign v_in = in_valid;
            assign n_in = dividend;
            assign r_in = '0;
            assign s_in = side_i;
        end else begin : g_next
            assign v_in = g_stage[i-1].v_reg;
            assign n_in = g_stage[i-1].n_reg;
            assign r_in = g_stage[i-1].r_reg;
            assign s_in = g_stage[i-1].s_reg;
        end

        assign sh    = {r_in, n_in[NW-1]};
        assign trial = {1'b0, sh} - {2'b00, divisor};
        assign ge    = ~trial[DW+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (en) begin
                v_reg <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg <= (n_in << 1) | NW'(ge);
                r_reg <= ge ? trial[DW-1:0] : sh[DW-1:0];
                s_reg <= s_in;
            end
        end
    end

    assign out_valid = g_stage[NW-1].v_reg;
    assign quot      = g_stage[NW-1].n_reg;
    assign rem       = g_stage[NW-1].r_reg;
    assign side_o    = g_stage[NW-1].s_reg;
endmodule

// ===== sv/dfops_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfops_front: request intake and classification
// Unpacks a request, tags switch or server, drops no-op commands.
// ----------------------------------------------------------------------------
module dfops_front (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dfops_pkg::S_DATA_W-1:0] s_tdata,
    input  dfops_pkg::cfg_t                cfg,
    input  logic                           q_full,
    output logic                           q_push,
    output dfops_pkg::item_t               q_item
);
    import dfops_pkg::*;

    logic [NODE_W-1:0] cur;

    assign cur      = s_tdata[17:2];
    assign s_tready = ~q_full;

    always_comb begin
        q_item        = '0;
        q_item.cmd    = cmd_t'(s_tdata[1:0]);
        q_item.is_sw  = (cur >= cfg.sc);
        q_item.cur_sw = cur - cfg.sc;
        q_item.dst    = s_tdata[33:18];
        q_item.proxy  = s_tdata[39:34];
        q_item.tidx   = s_tdata[51:40];
        q_item.tval   = s_tdata[63:52];
    end

    // no-op commands are taken and dropped here
    assign q_push = s_tvalid & ~q_full & (q_item.cmd != CMD_NOP);
endmodule

// ===== sv/dfops_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfops_queue: short request queue between intake and route pipeline
// Small circular buffer with occupancy count.
// ----------------------------------------------------------------------------
module dfops_queue #(
    parameter int DEPTH = dfops_pkg::Q_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  dfops_pkg::item_t din,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output dfops_pkg::item_t dout
);
    import dfops_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t           mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_pop;

    assign full   = (count_reg == CW'(DEPTH));
    assign valid  = (count_reg != '0);
    assign dout   = mem[rd_ptr_reg];
    assign do_pop = pop & valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CW'(push) - CW'(do_pop);
        end
    end
endmodule

// ===== sv/dfops_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfops_back: route pipeline
// Divider chain, group arithmetic, route and remap tables, output register.
// ----------------------------------------------------------------------------
module dfops_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  dfops_pkg::cfg_t                cfg,
    input  logic                           q_valid,
    input  dfops_pkg::item_t               q_item,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dfops_pkg::M_DATA_W-1:0] m_tdata
);
    import dfops_pkg::*;

    localparam int PSW   = $bits(pipe_t);
    localparam int RM_AW = (MAX_GROUP_PORTS > 1) ? $clog2(MAX_GROUP_PORTS) : 1;
    localparam logic [RT_AW-1:0] MG12 = RT_AW'(MAX_GROUPS);

    logic en;
    logic m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    assign en    = ~m_tvalid_reg | m_tready;
    assign q_pop = en & q_valid;

    // first divider pair: dst / p and cur_sw / a
    pipe_t q_pipe;
    logic  d1_v;
    logic [NODE_W-1:0] d1_qa, d1_qb;
    logic [CFG_W-1:0]  d1_ra, d1_rb;
    logic [PSW-1:0]    d1_side;
    pipe_t p1;

    always_comb begin
        q_pipe    = '0;
        q_pipe.it = q_item;
    end

    dfops_div #(.NW(NODE_W), .DW(CFG_W), .SW(PSW)) u_div_dst (
        .aclk, .aresetn, .en, .in_valid(q_valid), .dividend(q_item.dst),
        .divisor(cfg.p), .side_i(q_pipe), .out_valid(d1_v), .quot(d1_qa),
        .rem(d1_ra), .side_o(d1_side)
    );

    dfops_div #(.NW(NODE_W), .DW(CFG_W), .SW(1)) u_div_cur (
        .aclk, .aresetn, .en, .in_valid(q_valid), .dividend(q_item.cur_sw),
        .divisor(cfg.a), .side_i(1'b0), .out_valid(), .quot(d1_qb),
        .rem(d1_rb), .side_o()
    );

    always_comb begin
        p1          = pipe_t'(d1_side);
        p1.dst_sw   = d1_qa;
        p1.dst_mp   = d1_ra;
        p1.cur_grp  = d1_qb;
        p1.local_sw = d1_rb;
    end

    // second divider: dst_sw / a
    logic d2_v;
    logic [NODE_W-1:0] d2_q;
    logic [CFG_W-1:0]  d2_r;
    logic [PSW-1:0]    d2_side;
    pipe_t p2;

    dfops_div #(.NW(NODE_W), .DW(CFG_W), .SW(PSW)) u_div_grp (
        .aclk, .aresetn, .en, .in_valid(d1_v), .dividend(p1.dst_sw),
        .divisor(cfg.a), .side_i(p1), .out_valid(d2_v), .quot(d2_q),
        .rem(d2_r), .side_o(d2_side)
    );

    always_comb begin
        p2         = pipe_t'(d2_side);
        p2.dst_grp = d2_q;
        p2.dst_la  = d2_r;
    end

    // C1: local decisions, target group, absolute port, table address
    pipe_t c1_next, c1_reg;
    logic  c1_v_reg;
    logic [8:0]          intra;
    logic [NODE_W-1:0]   proxy16, tgt;
    logic [2*RT_AW-1:0]  rt_mul;
    logic                same_sw, same_grp;

    always_comb begin
        c1_next  = p2;
        same_sw  = (p2.it.cur_sw == p2.dst_sw);
        same_grp = (p2.cur_grp == p2.dst_grp);
        intra    = 9'(cfg.p) + 9'(p2.dst_la)
                 - ((p2.it.cur_sw > p2.dst_sw) ? 9'd0 : 9'd1);
        proxy16  = NODE_W'(p2.it.proxy);
        tgt      = (p2.cur_grp == proxy16) ? p2.dst_grp : proxy16;
        rt_mul   = p2.cur_grp[RT_AW-1:0] * MG12;
        c1_next.done   = ~p2.it.is_sw | same_sw | same_grp;
        c1_next.port   = ~p2.it.is_sw ? '0 : (same_sw ? PORT_W'(p2.dst_mp) : intra[7:0]);
        c1_next.tgt    = tgt;
        c1_next.diff   = 17'(tgt) - 17'(p2.cur_grp);
        c1_next.abs_og = (p2.cur_grp > tgt) ? tgt : tgt - 16'd1;
        c1_next.rt_idx = rt_mul[RT_AW-1:0] + tgt[RT_AW-1:0];
    end

    // C2: relative offset magnitude, circulant fold
    pipe_t c2_next, c2_reg;
    logic  c2_v_reg;
    logic [17:0] v, dsx;
    logic [16:0] dmag;

    always_comb begin
        c2_next       = c1_reg;
        dsx           = {c1_reg.diff[16], c1_reg.diff};
        v             = 18'(cfg.g) + dsx - 18'd1;
        c2_next.v_neg = v[17];
        c2_next.v_abs = v[17] ? 17'(18'd0 - v) : v[16:0];
        dmag          = c1_reg.diff[16] ? 17'd0 - c1_reg.diff : c1_reg.diff;
        if (dmag > 17'(cfg.g >> 1)) begin
            c2_next.ct = c1_reg.diff[16] ? dsx + 18'(cfg.g) : dsx - 18'(cfg.g);
        end else begin
            c2_next.ct = dsx;
        end
    end

    // C3: circulant port
    pipe_t c3_next, c3_reg;
    logic  c3_v_reg;
    logic [17:0] m2;
    logic [19:0] og20;

    always_comb begin
        c3_next = c2_reg;
        m2      = c2_reg.ct[17] ? 18'd0 - c2_reg.ct : c2_reg.ct;
        og20    = {1'b0, m2, 1'b0} - 20'd2 + 20'(c2_reg.ct[17]);
        if (og20 == 20'(cfg.g) - 20'd1) begin
            og20 = og20 - 20'd1;
        end
        c3_next.circ_og = og20[19] ? '0 : og20[OG_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_v_reg <= 1'b0;
            c2_v_reg <= 1'b0;
            c3_v_reg <= 1'b0;
        end else if (en) begin
            c1_v_reg <= d2_v;
            c2_v_reg <= c1_v_reg;
            c3_v_reg <= c2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg <= c1_next;
            c2_reg <= c2_next;
            c3_reg <= c3_next;
        end
    end

    // true modulo by group count
    logic d3_v;
    logic [CFG_W-1:0] d3_r;
    logic [PSW-1:0] d3_side;
    pipe_t p3;

    dfops_div #(.NW(17), .DW(CFG_W), .SW(PSW)) u_div_rel (
        .aclk, .aresetn, .en, .in_valid(c3_v_reg), .dividend(c3_reg.v_abs),
        .divisor(cfg.g), .side_i(c3_reg), .out_valid(d3_v), .quot(),
        .rem(d3_r), .side_o(d3_side)
    );

    always_comb begin
        p3    = pipe_t'(d3_side);
        p3.tm = (p3.v_neg && d3_r != '0) ? cfg.g - d3_r : d3_r;
    end

    // remap address: write index or relative offset, both below the table depth
    logic  d4_v;
    pipe_t p4;

    assign d4_v = d3_v;

    always_comb begin
        p4        = p3;
        p4.rm_idx = (p3.it.cmd == CMD_WR_RM) ? RM_IDX_W'(p3.it.tidx) : RM_IDX_W'(p3.tm);
    end

    // tables: writes and reads in pipeline order
    logic [TBL_W-1:0] rt_mem [ROUTE_DEPTH];
    logic [TBL_W-1:0] rm_mem [MAX_GROUP_PORTS];
    logic [TBL_W-1:0] rt_rd_reg, rm_rd_reg;
    pipe_t t_reg;
    logic  t_v_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (d4_v && p4.it.cmd == CMD_WR_RT) begin
                rt_mem[p4.it.tidx] <= p4.it.tval;
            end
            if (d4_v && p4.it.cmd == CMD_WR_RM) begin
                rm_mem[p4.rm_idx[RM_AW-1:0]] <= p4.it.tval;
            end
            rt_rd_reg <= rt_mem[p4.rt_idx];
            rm_rd_reg <= rm_mem[p4.rm_idx[RM_AW-1:0]];
            t_reg     <= p4;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_v_reg <= 1'b0;
        end else if (en) begin
            t_v_reg <= d4_v;
        end
    end

    // group port by wiring mode, then split into switch and uplink
    logic [OG_W-1:0] og;

    always_comb begin
        unique case (cfg.mode)
            MODE_ABS:   og = OG_W'(t_reg.abs_og);
            MODE_REL:   og = OG_W'(t_reg.tm);
            MODE_CIRC:  og = t_reg.circ_og;
            MODE_TABLE: og = OG_W'(rt_rd_reg);
            MODE_REMAP: og = OG_W'(rm_rd_reg);
            default:    og = '0;
        endcase
    end

    logic d5_v;
    logic [OG_W-1:0]  d5_q;
    logic [CFG_W-1:0] d5_r;
    logic [PSW-1:0]   d5_side;
    pipe_t p5;
    logic [OG_W-1:0] loc;
    logic [18:0]     glob;
    logic            mode_ok;
    logic [PORT_W-1:0] port;
    logic            err;

    dfops_div #(.NW(OG_W), .DW(CFG_W), .SW(PSW)) u_div_up (
        .aclk, .aresetn, .en, .in_valid(t_v_reg), .dividend(og),
        .divisor(cfg.h), .side_i(t_reg), .out_valid(d5_v), .quot(d5_q),
        .rem(d5_r), .side_o(d5_side)
    );

    always_comb begin
        p5      = pipe_t'(d5_side);
        loc     = OG_W'(p5.local_sw);
        mode_ok = (cfg.mode <= MODE_REMAP);
        if (d5_q == loc) begin
            glob = 19'(d5_r) + 19'(cfg.p) + 19'(cfg.a) - 19'd1;
        end else if (loc > d5_q) begin
            glob = 19'(cfg.p) + 19'(d5_q);
        end else begin
            glob = 19'(cfg.p) + 19'(d5_q) - 19'd1;
        end
        priority if (p5.done) begin
            port = p5.port;
            err  = 1'b0;
        end else if (!mode_ok) begin
            port = '0;
            err  = 1'b1;
        end else begin
            port = glob[PORT_W-1:0];
            err  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= d5_v & (p5.it.cmd == CMD_ROUTE);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {7'd0, err, port};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
endmodule

// ===== sv/dfops_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfops_checker: port-level checks for output port selection
// Watches the result channel; bound to the top level.
// ----------------------------------------------------------------------------
module dfops_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [dfops_pkg::M_DATA_W-1:0]   m_tdata
);
    // a stalled result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a mode error always carries port zero
    a_err_port: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> m_tdata[7:0] == 8'd0)
        else $error("mode error with nonzero port");

    // padding bits stay clear
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:9] == 7'd0)
        else $error("result padding not zero");

    // reset empties the output register
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
endmodule

bind dragonfly_output_port_select dfops_checker u_dfops_checker (.*);
